// ===== sv/qvr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and types for the quaternion vector rotation pipeline.
// No dependencies.
package qvr_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // one term of q*v, sum of three terms, one term of p*conj(q), sum of four terms
    localparam int PROD1_W    = 2 * COMP_WIDTH;
    localparam int SUM1_W     = PROD1_W + 2;
    localparam int PROD2_W    = SUM1_W + COMP_WIDTH;
    localparam int SUM2_W     = PROD2_W + 2;
    localparam int RND_W      = SUM2_W + 1;
    localparam int SHIFT      = 2 * FRAC_BITS;

    localparam int NUM_STAGES = 5;
    localparam int NUM_TERMS  = 12;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;
    typedef logic signed [PROD1_W-1:0]    t_prod1;
    typedef logic signed [SUM1_W-1:0]     t_sum1;
    typedef logic signed [PROD2_W-1:0]    t_prod2;
    typedef logic signed [SUM2_W-1:0]     t_sum2;
    typedef logic signed [RND_W-1:0]      t_rnd;

endpackage

// ===== sv/quaternion_vector_rotate.sv =====
`timescale 1ns / 1ps
// Five register stages; o_out_valid rises once an accepted input reaches the last stage.
// One item per cycle unless the full pipe stalls; two multiplier stages of twelve products each.
// Each stage holds its own valid bit, so a waiting result does not stop stages behind bubbles.
// Reset (synchronous, active low) clears only the stage valid bits.
// Depends on qvr_pkg.
module quaternion_vector_rotate import qvr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_comp i_quat_x,
    input  t_comp i_quat_y,
    input  t_comp i_quat_z,
    input  t_comp i_quat_w,
    input  t_comp i_vec_x,
    input  t_comp i_vec_y,
    input  t_comp i_vec_z,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_comp o_rot_x,
    output t_comp o_rot_y,
    output t_comp o_rot_z
);

    localparam t_rnd HALF = t_rnd'(1) <<< (SHIFT - 1);
    localparam t_rnd MAXV = (t_rnd'(1) <<< (COMP_WIDTH - 1)) - t_rnd'(1);
    localparam t_rnd MINV = -MAXV - t_rnd'(1);

    function automatic t_comp round_sat(input t_sum2 a);
        t_rnd v;
        v = (t_rnd'(a) + HALF) >>> SHIFT;
        if (v > MAXV) begin
            v = MAXV;
        end else if (v < MINV) begin
            v = MINV;
        end
        return t_comp'(v);
    endfunction

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stg_adv;

    t_prod1 r_m1 [NUM_TERMS];
    t_prod1 n_m1 [NUM_TERMS];
    t_comp  r_q1x, r_q1y, r_q1z, r_q1w;
    t_sum1  r_px, r_py, r_pz, r_pw;
    t_sum1  n_px, n_py, n_pz, n_pw;
    t_comp  r_q2x, r_q2y, r_q2z, r_q2w;
    t_prod2 r_m2 [NUM_TERMS];
    t_prod2 n_m2 [NUM_TERMS];
    t_sum2  r_rx, r_ry, r_rz;
    t_sum2  n_rx, n_ry, n_rz;
    t_comp  r_ox, r_oy, r_oz;

    always_comb begin
        stg_adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stg_adv[k] = !r_vld[k] || stg_adv[k+1];
        end
    end

    assign o_in_ready  = stg_adv[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_rot_x     = r_ox;
    assign o_rot_y     = r_oy;
    assign o_rot_z     = r_oz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stg_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: terms of q * (v, 0)
    always_comb begin
        n_m1[0]  = t_prod1'(i_vec_x) * t_prod1'(i_quat_w);
        n_m1[1]  = t_prod1'(i_vec_z) * t_prod1'(i_quat_y);
        n_m1[2]  = t_prod1'(i_vec_y) * t_prod1'(i_quat_z);
        n_m1[3]  = t_prod1'(i_vec_y) * t_prod1'(i_quat_w);
        n_m1[4]  = t_prod1'(i_vec_z) * t_prod1'(i_quat_x);
        n_m1[5]  = t_prod1'(i_vec_x) * t_prod1'(i_quat_z);
        n_m1[6]  = t_prod1'(i_vec_z) * t_prod1'(i_quat_w);
        n_m1[7]  = t_prod1'(i_vec_y) * t_prod1'(i_quat_x);
        n_m1[8]  = t_prod1'(i_vec_x) * t_prod1'(i_quat_y);
        n_m1[9]  = t_prod1'(i_vec_x) * t_prod1'(i_quat_x);
        n_m1[10] = t_prod1'(i_vec_y) * t_prod1'(i_quat_y);
        n_m1[11] = t_prod1'(i_vec_z) * t_prod1'(i_quat_z);
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[0]) begin
            r_m1  <= n_m1;
            r_q1x <= i_quat_x;
            r_q1y <= i_quat_y;
            r_q1z <= i_quat_z;
            r_q1w <= i_quat_w;
        end
    end

    // stage 2: p = q * (v, 0)
    always_comb begin
        n_px = t_sum1'(r_m1[0]) + t_sum1'(r_m1[1]) - t_sum1'(r_m1[2]);
        n_py = t_sum1'(r_m1[3]) - t_sum1'(r_m1[4]) + t_sum1'(r_m1[5]);
        n_pz = t_sum1'(r_m1[6]) + t_sum1'(r_m1[7]) - t_sum1'(r_m1[8]);
        n_pw = -(t_sum1'(r_m1[9]) + t_sum1'(r_m1[10]) + t_sum1'(r_m1[11]));
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[1]) begin
            r_px  <= n_px;
            r_py  <= n_py;
            r_pz  <= n_pz;
            r_pw  <= n_pw;
            r_q2x <= r_q1x;
            r_q2y <= r_q1y;
            r_q2z <= r_q1z;
            r_q2w <= r_q1w;
        end
    end

    // stage 3: terms of p * conj(q)
    always_comb begin
        n_m2[0]  = t_prod2'(r_px) * t_prod2'(r_q2w);
        n_m2[1]  = t_prod2'(r_pw) * t_prod2'(r_q2x);
        n_m2[2]  = t_prod2'(r_py) * t_prod2'(r_q2z);
        n_m2[3]  = t_prod2'(r_pz) * t_prod2'(r_q2y);
        n_m2[4]  = t_prod2'(r_py) * t_prod2'(r_q2w);
        n_m2[5]  = t_prod2'(r_pw) * t_prod2'(r_q2y);
        n_m2[6]  = t_prod2'(r_px) * t_prod2'(r_q2z);
        n_m2[7]  = t_prod2'(r_pz) * t_prod2'(r_q2x);
        n_m2[8]  = t_prod2'(r_pz) * t_prod2'(r_q2w);
        n_m2[9]  = t_prod2'(r_pw) * t_prod2'(r_q2z);
        n_m2[10] = t_prod2'(r_px) * t_prod2'(r_q2y);
        n_m2[11] = t_prod2'(r_py) * t_prod2'(r_q2x);
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[2]) begin
            r_m2 <= n_m2;
        end
    end

    // stage 4: vector part of p * conj(q)
    always_comb begin
        n_rx = t_sum2'(r_m2[0]) - t_sum2'(r_m2[1]) - t_sum2'(r_m2[2]) + t_sum2'(r_m2[3]);
        n_ry = t_sum2'(r_m2[4]) - t_sum2'(r_m2[5]) + t_sum2'(r_m2[6]) - t_sum2'(r_m2[7]);
        n_rz = t_sum2'(r_m2[8]) - t_sum2'(r_m2[9]) - t_sum2'(r_m2[10]) + t_sum2'(r_m2[11]);
    end

    always_ff @(posedge i_clk) begin
        if (stg_adv[3]) begin
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rz <= n_rz;
        end
    end

    // stage 5: round half up and saturate
    always_ff @(posedge i_clk) begin
        if (stg_adv[4]) begin
            r_ox <= round_sat(r_rx);
            r_oy <= round_sat(r_ry);
            r_oz <= round_sat(r_rz);
        end
    end

endmodule

// ===== sv/qvr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for quaternion_vector_rotate, bound to the top level.
// Depends on qvr_pkg and quaternion_vector_rotate.
module qvr_checker import qvr_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_in_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_comp o_rot_x,
    input t_comp o_rot_y,
    input t_comp o_rot_z
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_rot_x) && $stable(o_rot_y) && $stable(o_rot_z))
        else $error("stalled result dropped or changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_rot_x     (o_rot_x),
    .o_rot_y     (o_rot_y),
    .o_rot_z     (o_rot_z)
);
